@@ src/ttce_pkg.sv @@
// Package for the text terminal character engine.
// Holds the screen geometry, character codes, function codes and payload types.
// No dependencies.
package ttce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int ADDR_W    = 11;
  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int FUNC_W    = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

  localparam logic REG_ATTR = 1'b0;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_location;
    logic [CELL_W-1:0] cell_data;
    logic              did_scroll;
  } res_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             write_cell;
    logic             scroll;
  } cursor_t;

  function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    return ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

@@ src/ttce_cursor.sv @@
// Cursor update for one put byte: control codes, printable advance, wrap, scroll.
// Depends on ttce_pkg.
module ttce_cursor (
  input  logic [ttce_pkg::COL_W-1:0]  col_i,
  input  logic [ttce_pkg::ROW_W-1:0]  row_i,
  input  logic [ttce_pkg::CHAR_W-1:0] char_i,
  output ttce_pkg::cursor_t           cursor_o
);
  import ttce_pkg::*;

  logic [COL_W:0] col_w;
  logic [ROW_W:0] row_w;
  logic [COL_W:0] col_t;
  logic [ROW_W:0] row_t;
  logic           printable;

  assign col_w     = {1'b0, col_i};
  assign row_w     = {1'b0, row_i};
  assign printable = (char_i[7:5] != 3'b000) && !char_i[7];

  always_comb begin
    col_t = col_w;
    row_t = row_w;
    case (char_i)
      CH_BS: begin
        if (col_w != '0) begin
          col_t = col_w - 1'b1;
        end
      end
      CH_TAB: begin
        col_t = col_w - (COL_W+1)'(col_w % TAB_STOP) + (COL_W+1)'(TAB_STOP);
      end
      CH_CR: begin
        col_t = '0;
      end
      CH_LF: begin
        col_t = '0;
        row_t = row_w + 1'b1;
      end
      default: begin
        if (printable) begin
          col_t = col_w + 1'b1;
        end
      end
    endcase
    if (col_t >= (COL_W+1)'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    cursor_o.write_cell = printable;
    cursor_o.col        = col_t[COL_W-1:0];
    cursor_o.scroll     = row_t >= (ROW_W+1)'(ROWS);
    cursor_o.row        = cursor_o.scroll ? ROW_W'(ROWS - 1) : row_t[ROW_W-1:0];
  end

endmodule

@@ src/text_terminal_char_engine.sv @@
// Text terminal character engine top level: screen memory, sequencer, APB register.
// Depends on ttce_pkg and ttce_cursor.
//
//  channel | ports                                          | transfer
//  --------+------------------------------------------------+---------------------------------
//  command | start, busy, cmd_i                             | start high while busy low
//  result  | done_o, res_o                                  | done_o high for one cycle
//  config  | psel penable pwrite paddr pwdata prdata pready | psel & penable & pwrite & pready
//
// Put without scroll or unused code: result in the cycle after the transfer; read: via ST_READ and the result register.
// Scroll: busy for 1920 cell moves plus 80 blank writes through the single write port of the
// screen memory, result registered after the last write; clear: 2000 blank writes, likewise.
// After reset the screen memory is swept to blank, 2000 writes with busy high.
// The receiver cannot stall; busy stays low for a put without scroll or an unused code and
// is otherwise high from the transfer until the result strobe.
module text_terminal_char_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  ttce_pkg::cmd_t                cmd_i,
  output logic                          done_o,
  output ttce_pkg::res_t                res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttce_pkg::PADDR_W-1:0]  paddr,
  input  logic [ttce_pkg::PDATA_W-1:0]  pwdata,
  output logic [ttce_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ttce_pkg::*;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_MOVE
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   ptr_q, ptr_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [ATTR_W-1:0]   attr_q;
  logic [CELL_W-1:0]   fill_q, fill_d;
  logic                report_q, report_d;
  logic                scroll_q, scroll_d;
  logic                rd_ok_q, rd_ok_d;
  logic                done_q, done_d;
  res_t                res_q, res_d;

  logic [CELL_W-1:0]   mem_q [CELL_COUNT];
  logic [CELL_W-1:0]   rdata_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  logic                accept;
  logic                cfg_write;
  cursor_t             cursor;

  ttce_cursor u_cursor (
    .col_i    (col_q),
    .row_i    (row_q),
    .char_i   (cmd_i.char_code),
    .cursor_o (cursor)
  );

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_ATTR) ? PDATA_W'(attr_q) : '0;
  assign done_o    = done_q;
  assign res_o     = res_q;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    col_d     = col_q;
    row_d     = row_q;
    fill_d    = fill_q;
    report_d  = report_q;
    scroll_d  = scroll_q;
    rd_ok_d   = rd_ok_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = fill_q;
    mem_raddr = ptr_q + ADDR_W'(COLUMNS + 1);
    res_d     = '0;
    case (state_q)
      ST_IDLE: begin
        mem_raddr = (cmd_i.func == FN_READ) ? cmd_i.cell_address : ADDR_W'(COLUMNS);
        if (accept) begin
          case (cmd_i.func)
            FN_PUT: begin
              col_d     = cursor.col;
              row_d     = cursor.row;
              mem_we    = cursor.write_cell;
              mem_waddr = cell_index(row_q, col_q);
              mem_wdata = {attr_q, cmd_i.char_code};
              if (cursor.scroll) begin
                state_d  = ST_MOVE;
                ptr_d    = '0;
                fill_d   = {attr_q, CH_SPACE};
                report_d = 1'b1;
                scroll_d = 1'b1;
              end else begin
                done_d = 1'b1;
              end
            end
            FN_READ: begin
              state_d = ST_READ;
              rd_ok_d = cmd_i.cell_address < ADDR_W'(CELL_COUNT);
            end
            FN_CLEAR: begin
              col_d    = '0;
              row_d    = '0;
              state_d  = ST_FILL;
              ptr_d    = '0;
              fill_d   = {attr_q, CH_SPACE};
              report_d = 1'b1;
              scroll_d = 1'b0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d          = 1'b1;
        state_d         = ST_IDLE;
        res_d.cell_data = rd_ok_q ? rdata_q : '0;
      end
      ST_MOVE: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == ADDR_W'(CELL_COUNT - COLUMNS - 1)) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d          = ST_IDLE;
          done_d           = report_q;
          res_d.did_scroll = scroll_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    res_d.cursor_col      = col_d;
    res_d.cursor_row      = row_d;
    res_d.cursor_location = cell_index(row_d, col_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      ptr_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      attr_q   <= ATTR_RESET;
      fill_q   <= {ATTR_RESET, CH_SPACE};
      report_q <= 1'b0;
      scroll_q <= 1'b0;
      rd_ok_q  <= 1'b0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      col_q    <= col_d;
      row_q    <= row_d;
      fill_q   <= fill_d;
      report_q <= report_d;
      scroll_q <= scroll_d;
      rd_ok_q  <= rd_ok_d;
      done_q   <= done_d;
      if (done_d) begin
        res_q <= res_d;
      end
      if (cfg_write && paddr[2] == REG_ATTR) begin
        attr_q <= pwdata[ATTR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.cursor_row < ROW_W'(ROWS)) && (res_o.cursor_col < COL_W'(COLUMNS)))
    else $error("cursor out of screen");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.did_scroll) |-> res_o.cursor_row == ROW_W'(ROWS - 1))
    else $error("scroll did not leave cursor on last row");

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.func == FN_READ) |=> busy ##1 done_o)
    else $error("read result not delivered two cycles after transfer");

endmodule

@@ tb/sv/tb_ttce_checker.sv @@
`timescale 1ns / 1ps
// Checker for the text terminal character engine: tracks screen, cursor and attribute,
// predicts the report of every command transfer and compares it with each result strobe.
// Depends on ttce_pkg.
module tb_ttce_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  ttce_pkg::cmd_t               cmd_i,
  input  logic                         done_i,
  input  ttce_pkg::res_t               res_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [ttce_pkg::PADDR_W-1:0] paddr_i,
  input  logic [ttce_pkg::PDATA_W-1:0] pwdata_i,
  input  logic                         pready_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           scroll_count_o
);
  import ttce_pkg::*;

  logic [CELL_W-1:0] screen [CELL_COUNT];
  logic [ATTR_W-1:0] attr;
  int                col_pos;
  int                row_pos;
  res_t              cursor_reports_q [$];
  res_t              predicted;
  res_t              oldest;
  int                fails;
  int                scrolls;
  int                pending;

  assign fail_count_o   = fails;
  assign pending_o      = pending;
  assign scroll_count_o = scrolls;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic apply_terminal_cmd(input cmd_t c, output res_t r);
    logic [CELL_W-1:0] data;
    logic              rolled;
    int                i;
    data   = '0;
    rolled = 1'b0;
    case (c.func)
      FN_PUT: begin
        case (c.char_code)
          CH_BS: begin
            if (col_pos > 0) col_pos--;
          end
          CH_TAB: col_pos = col_pos + TAB_STOP - (col_pos % TAB_STOP);
          CH_CR:  col_pos = 0;
          CH_LF: begin
            col_pos = 0;
            row_pos++;
          end
          default: begin
            if (c.char_code >= CH_SPACE && !c.char_code[CHAR_W-1]) begin
              screen[row_pos * COLUMNS + col_pos] = {attr, c.char_code};
              col_pos++;
            end
          end
        endcase
        if (col_pos >= COLUMNS) begin
          col_pos = 0;
          row_pos++;
        end
        if (row_pos >= ROWS) begin
          for (i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = {attr, CH_SPACE};
          row_pos = ROWS - 1;
          rolled  = 1'b1;
        end
      end
      FN_READ: begin
        if (c.cell_address < CELL_COUNT) data = screen[c.cell_address];
      end
      FN_CLEAR: begin
        for (i = 0; i < CELL_COUNT; i++) screen[i] = {attr, CH_SPACE};
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
    r.cursor_col      = COL_W'(col_pos);
    r.cursor_row      = ROW_W'(row_pos);
    r.cursor_location = ADDR_W'(row_pos * COLUMNS + col_pos);
    r.cell_data       = data;
    r.did_scroll      = rolled;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELL_COUNT; i++) screen[i] = {ATTR_RESET, CH_SPACE};
      attr    = ATTR_RESET;
      col_pos = 0;
      row_pos = 0;
      cursor_reports_q.delete();
      fails   = 0;
      scrolls = 0;
      pending = 0;
    end else begin
      if (done_i) begin
        if (cursor_reports_q.size() == 0) begin
          fails++;
          $display("%0t ns: unexpected result, expected none, actual %h", $time, res_i);
        end else begin
          oldest = cursor_reports_q.pop_front();
          check_field("cursor_col", 32'(oldest.cursor_col), 32'(res_i.cursor_col));
          check_field("cursor_row", 32'(oldest.cursor_row), 32'(res_i.cursor_row));
          check_field("cursor_location", 32'(oldest.cursor_location),
                      32'(res_i.cursor_location));
          check_field("cell_data", 32'(oldest.cell_data), 32'(res_i.cell_data));
          check_field("did_scroll", 32'(oldest.did_scroll), 32'(res_i.did_scroll));
        end
      end
      if (start_i && !busy_i) begin
        apply_terminal_cmd(cmd_i, predicted);
        if (predicted.did_scroll) scrolls++;
        cursor_reports_q.push_back(predicted);
      end
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[PADDR_W-1:2] == REG_ATTR && paddr_i[1:0] == 2'b00) begin
        attr = pwdata_i[ATTR_W-1:0];
      end
      pending = cursor_reports_q.size();
    end
  end

endmodule

@@ tb/sv/tb_text_terminal_char_engine.sv @@
`timescale 1ns / 1ps
// Testbench top for the text terminal character engine: clock, reset, command and APB
// stimulus, and the verdict. Depends on ttce_pkg, text_terminal_char_engine, tb_ttce_checker.
module tb_text_terminal_char_engine;
  import ttce_pkg::*;

  localparam logic [FUNC_W-1:0]  FN_UNUSED   = 2'd3;
  localparam logic [PADDR_W-1:0] ATTR_ADDR   = PADDR_W'(4 * int'(REG_ATTR));
  localparam logic [PADDR_W-1:0] SPARE_ADDR  = PADDR_W'(4 * (int'(REG_ATTR) + 1));
  localparam int                 PHASES      = 8;
  localparam int                 PHASE_ITEMS = 204;
  localparam int                 DRAIN_LIMIT = 20000;
  localparam int                 TAIL_CYCLES = 2100;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  cmd_t               cmd     = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic               busy;
  logic               done;
  res_t               res;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;
  int scroll_count;
  bit idle_on;
  int n_put;
  int n_read;
  int n_clear;
  int n_other;
  int n_reg;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  text_terminal_char_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd),
    .done_o  (done),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tb_ttce_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .done_i         (done),
    .res_i          (res),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .scroll_count_o (scroll_count)
  );

  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    case (c.func)
      FN_PUT:   n_put++;
      FN_READ:  n_read++;
      FN_CLEAR: n_clear++;
      default:  n_other++;
    endcase
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_cmd('{func: FN_PUT, char_code: ch, cell_address: ADDR_W'($urandom)});
  endtask

  task automatic read_cell(input int addr);
    send_cmd('{func: FN_READ, char_code: CHAR_W'($urandom), cell_address: ADDR_W'(addr)});
  endtask

  // hold start low until every report is in and the engine is free
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_reg++;
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    c.func         = FN_PUT;
    c.char_code    = CHAR_W'($urandom);
    c.cell_address = ADDR_W'($urandom);
    pick = $urandom_range(0, 999);
    if (pick < 700) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      c.char_code = CHAR_W'($urandom_range(32, 127));
      else if (pick < 75) c.char_code = CH_LF;
      else if (pick < 79) c.char_code = CH_CR;
      else if (pick < 84) c.char_code = CH_TAB;
      else if (pick < 89) c.char_code = CH_BS;
    end else if (pick < 986) begin
      c.func = FN_READ;
      if ($urandom_range(0, 9) != 0) c.cell_address = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
    end else if (pick < 988) begin
      c.func = FN_CLEAR;
    end else begin
      c.func = FN_UNUSED;
    end
    return c;
  endfunction

  initial begin
    logic [ATTR_W-1:0] attr_val;
    int                n;
    idle_on = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    wait_idle();
    write_reg(SPARE_ADDR, '1);

    read_cell(0);
    read_cell(CELL_COUNT - 1);
    read_cell(CELL_COUNT);
    read_cell((1 << ADDR_W) - 1);
    put_char(8'h41);
    put_char(8'h7F);
    put_char(CH_SPACE);
    put_char(CH_BS);
    put_char(CH_TAB);
    put_char(CH_TAB);
    put_char(CH_CR);
    put_char(CH_BS);
    put_char(8'h80);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(8'h1F);
    put_char(CH_LF);
    read_cell(0);
    read_cell(1);
    send_cmd('{func: FN_UNUSED, char_code: '1, cell_address: '1});
    send_cmd('{func: FN_CLEAR, char_code: '0, cell_address: '0});
    read_cell(0);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       attr_val = 8'h00;
        1:       attr_val = 8'hFF;
        default: attr_val = ATTR_W'($urandom_range(1, 254));
      endcase
      write_reg(ATTR_ADDR, {(PDATA_W - ATTR_W)'($urandom), attr_val});
      if (ph == 4) write_reg(SPARE_ADDR, $urandom);
      idle_on = (ph % 3) != 2;
      repeat (PHASE_ITEMS) send_cmd(random_cmd());
    end

    start <= 1'b0;
    n = 0;
    while (n < DRAIN_LIMIT && (pending != 0 || busy)) begin
      @(negedge clk_i);
      n++;
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("tb: %0d commands (%0d put, %0d read, %0d clear, %0d unused code), %0d scrolls",
             n_put + n_read + n_clear + n_other, n_put, n_read, n_clear, n_other,
             scroll_count);
    $display("tb: %0d register writes, attribute at reset, 0x00, 0xFF and random values",
             n_reg);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
